@@ rtl/cmix_pkg.sv @@
// ----------------------------------------------------------------------------
// cmix_pkg : shared types and constants of the crossfade mixer
// Sample formats, link bundle between cells and configuration indexes.
// ----------------------------------------------------------------------------
package cmix_pkg;

    localparam int SIGNAL_COUNT  = 8;   // signals mixed (2..8)
    localparam int SIGNAL_FIELDS = 8;   // signal fields present in an item
    localparam int CELL_COUNT    = (SIGNAL_COUNT < SIGNAL_FIELDS) ? SIGNAL_COUNT
                                                                  : SIGNAL_FIELDS;

    localparam int SAMPLE_W = 24;       // Q1.23
    localparam int LEVEL_W  = 24;       // unsigned level registers
    localparam int RECIP_W  = 41;       // 2^40 / segment width
    localparam int PEAK_W   = 27;       // start + k * width, k < 8
    localparam int WEIGHT_W = 17;       // Q1.16, up to 1.0
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W    = PROD_W + $clog2(CELL_COUNT);
    localparam int DATA_W   = SAMPLE_W * (SIGNAL_FIELDS + 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = RECIP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_END_LEVEL     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_WIDTH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_RECIP = CFG_IDX_W'(3);

    typedef logic [SIGNAL_FIELDS-1:0][SAMPLE_W-1:0] sig_vec_t;

    // bundle handed from cell to cell
    typedef struct packed {
        logic [LEVEL_W-1:0]      pos;    // clamped mix position
        logic [PEAK_W-1:0]       peak;   // peak of the signal this cell serves
        logic signed [ACC_W-1:0] acc;    // running weighted sum
        sig_vec_t                sig;    // remaining signals, current in lane 0
    } link_t;

endpackage

@@ rtl/cmix_front.sv @@
// ----------------------------------------------------------------------------
// cmix_front : modulation magnitude, clamp and link start
// Loads one item into the head of the cell chain.
// ----------------------------------------------------------------------------
module cmix_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic signed [cmix_pkg::SAMPLE_W-1:0] modulation,
    input  cmix_pkg::sig_vec_t                signals,
    input  logic [cmix_pkg::LEVEL_W-1:0]      lo_bound,
    input  logic [cmix_pkg::LEVEL_W-1:0]      hi_bound,
    output logic                              out_valid,
    output cmix_pkg::link_t                   out_link
);
    import cmix_pkg::*;

    logic [LEVEL_W-1:0] mag;
    logic [LEVEL_W-1:0] pos;
    logic               valid_reg;
    link_t              link_reg;
    link_t              link_next;

    // magnitude of the most negative sample wraps to 2^23, still correct unsigned
    assign mag = modulation[SAMPLE_W-1] ? LEVEL_W'(~modulation + 1'b1)
                                        : LEVEL_W'(modulation);

    always_comb
    begin
        // when start lies above end, a magnitude below start gives start, else end
        if (mag < lo_bound)
            pos = lo_bound;
        else if (mag > hi_bound)
            pos = hi_bound;
        else
            pos = mag;
        link_next.pos  = pos;
        link_next.peak = PEAK_W'(lo_bound);
        link_next.acc  = '0;
        link_next.sig  = signals;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            link_reg <= link_next;
    end

    assign out_valid = valid_reg;
    assign out_link  = link_reg;

endmodule

@@ rtl/cmix_cell.sv @@
// ----------------------------------------------------------------------------
// cmix_cell : one crossfade cell
// Weights the signal in lane 0 and adds it to the sum; four register stages.
// ----------------------------------------------------------------------------
module cmix_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  cmix_pkg::link_t               in_link,
    input  logic [cmix_pkg::LEVEL_W-1:0]  segment_width,
    input  logic [cmix_pkg::RECIP_W-1:0]  segment_reciprocal,
    output logic                          out_valid,
    output cmix_pkg::link_t               out_link
);
    import cmix_pkg::*;

    localparam int LO_W = 24;                 // low part of the reciprocal
    localparam int HI_W = RECIP_W - LO_W;

    logic [3:0]                 valid_reg;
    link_t                      a_link_reg, b_link_reg, c_link_reg, d_link_reg;
    link_t                      a_link_next, d_link_next;
    logic [LEVEL_W-1:0]         span_reg, span_next;
    logic [LEVEL_W+HI_W-1:0]    hi_reg;
    logic [LEVEL_W+LO_W-1:0]    lo_reg;
    logic [WEIGHT_W-1:0]        weight_reg, weight_next;

    logic signed [PEAK_W:0]     diff;
    logic [PEAK_W-1:0]          delta;
    logic [LEVEL_W+HI_W:0]      wsum;
    logic signed [PROD_W-1:0]   prod;

    // stage A: distance to this cell's peak, span left inside the triangle
    always_comb
    begin
        diff  = $signed({4'b0, in_link.pos}) - $signed({1'b0, in_link.peak});
        delta = diff[PEAK_W] ? PEAK_W'(-diff) : PEAK_W'(diff);
        if (delta <= PEAK_W'(segment_width))
            span_next = segment_width - delta[LEVEL_W-1:0];
        else
            span_next = '0;
        a_link_next      = in_link;
        a_link_next.peak = in_link.peak + PEAK_W'(segment_width);
    end

    // stage C: recombine the two partial products, saturate at 1.0
    always_comb
    begin
        wsum = (LEVEL_W+HI_W+1)'(hi_reg) + (LEVEL_W+HI_W+1)'(lo_reg[LEVEL_W+LO_W-1:LO_W]);
        if (wsum > (LEVEL_W+HI_W+1)'(WEIGHT_ONE))
            weight_next = WEIGHT_ONE;
        else
            weight_next = wsum[WEIGHT_W-1:0];
    end

    // stage D: multiply-accumulate, shift the next signal into lane 0
    always_comb
    begin
        prod = $signed(c_link_reg.sig[0]) * $signed({1'b0, weight_reg});
        d_link_next     = c_link_reg;
        d_link_next.acc = c_link_reg.acc + ACC_W'(prod);
        for (int i = 0; i < SIGNAL_FIELDS - 1; i++)
            d_link_next.sig[i] = c_link_reg.sig[i+1];
        d_link_next.sig[SIGNAL_FIELDS-1] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_link_reg <= a_link_next;
            span_reg   <= span_next;
            b_link_reg <= a_link_reg;
            hi_reg     <= span_reg * segment_reciprocal[RECIP_W-1:LO_W];
            lo_reg     <= span_reg * segment_reciprocal[LO_W-1:0];
            c_link_reg <= b_link_reg;
            weight_reg <= weight_next;
            d_link_reg <= d_link_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_link  = d_link_reg;

endmodule

@@ rtl/multi_signal_crossfade_mixer.sv @@
// ----------------------------------------------------------------------------
// multi_signal_crossfade_mixer : N-way linear crossfade mixer
// Mixes eight Q1.23 signals with triangular weights chosen by |modulation|.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       modulation, signal_0..7
//  m_axis    out        m_axis_tvalid/tready       mixed_sample
//  cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
//  One item per cycle sustained while the output is not stalled. An item
//  passes the clamp register, the chain of cells and the output register,
//  each cell running one 41-bit weight product as two partial products.
//  Reset is asynchronous, active low, and clears the valid flags and the
//  configuration registers to their defaults.
//  The whole chain advances together: a stalled output holds every stage and
//  drops s_axis_tready, which otherwise stays high while results drain.
//
module multi_signal_crossfade_mixer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // fields from bit 0: modulation, signal_0 .. signal_7 (24 bits each)
    input  logic [cmix_pkg::DATA_W-1:0]       s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // fields from bit 0: mixed_sample (24 bits)
    output logic [cmix_pkg::SAMPLE_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cmix_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmix_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cmix_pkg::*;

    localparam int RES_W = ACC_W - 16;

    // configuration
    logic [LEVEL_W-1:0] lo_bound_reg;
    logic [LEVEL_W-1:0] hi_bound_reg;
    logic [LEVEL_W-1:0] seg_width_reg;
    logic [RECIP_W-1:0] seg_recip_reg;

    // chain
    logic                         adv;
    logic [CELL_COUNT:0]          chain_valid;
    link_t [CELL_COUNT:0]         chain_link;
    sig_vec_t                     in_sig;

    // output stage
    logic                         out_valid_reg;
    logic [SAMPLE_W-1:0]          out_data_reg;
    logic [SAMPLE_W-1:0]          out_data_next;
    logic signed [RES_W-1:0]      res;

    // configuration writes are taken every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_bound_reg  <= LEVEL_W'(0);
            hi_bound_reg  <= LEVEL_W'(8388608);
            seg_width_reg <= LEVEL_W'(1048576);
            seg_recip_reg <= RECIP_W'(1048576);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_LEVEL:   lo_bound_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_END_LEVEL:     hi_bound_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_SEGMENT_WIDTH: seg_width_reg <= cfg_data[LEVEL_W-1:0];
                CFG_SEGMENT_RECIP: seg_recip_reg <= cfg_data;
                default:           ;  // unknown index, ignored
            endcase
        end
    end

    // whole chain moves when the output register is free or being emptied
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        for (int k = 0; k < SIGNAL_FIELDS; k++)
            in_sig[k] = s_axis_tdata[SAMPLE_W*(k+1) +: SAMPLE_W];
    end

    cmix_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s_axis_tvalid),
        .modulation  ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .signals     (in_sig),
        .lo_bound    (lo_bound_reg),
        .hi_bound    (hi_bound_reg),
        .out_valid   (chain_valid[0]),
        .out_link    (chain_link[0])
    );

    // one cell per mixed signal; each consumes lane 0 and shifts the rest down
    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        cmix_cell u_cell
        (
            .clk                (clk),
            .rst_n              (rst_n),
            .adv                (adv),
            .in_valid           (chain_valid[k]),
            .in_link            (chain_link[k]),
            .segment_width      (seg_width_reg),
            .segment_reciprocal (seg_recip_reg),
            .out_valid          (chain_valid[k+1]),
            .out_link           (chain_link[k+1])
        );
    end

    // floor of sum / 2^16, then clip to Q1.23
    always_comb
    begin
        res = RES_W'(chain_link[CELL_COUNT].acc >>> 16);
        if (res > RES_W'(8388607))
            out_data_next = SAMPLE_W'(24'h7FFFFF);
        else if (res < -RES_W'(8388608))
            out_data_next = SAMPLE_W'(24'h800000);
        else
            out_data_next = res[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= chain_valid[CELL_COUNT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ rtl/cmix_checker.sv @@
// ----------------------------------------------------------------------------
// cmix_checker : port-level checks of the crossfade mixer
// Watches handshakes and flow control at the top level.
// ----------------------------------------------------------------------------
module cmix_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic [cmix_pkg::SAMPLE_W-1:0]     m_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic                              cfg_ready
);
    import cmix_pkg::*;

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // a held result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input side stalls only behind a blocked result
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready out of step with output stall");

    // nothing comes out straight after reset: the chain starts empty
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port refused a write");

endmodule

bind multi_signal_crossfade_mixer cmix_checker u_cmix_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_ready     (cfg_ready)
);
